FILE: design/efws_pkg.sv
// shared types, constants and ordering function of the earliest free worker scheduler
`default_nettype none

package efws_pkg;

  localparam int TimeW = 48;
  localparam int IdxW = 4;
  localparam int DurW = 32;
  localparam int CntW = 5;
  localparam int DataW = 32;
  localparam int AddrW = 3;
  localparam int RegIdxW = AddrW - 2;

  localparam int MaxWorkersDefault = 16;
  localparam int IdxLimit = 16;
  localparam logic [CntW-1:0] CountReset = CntW'(16);

  localparam logic [RegIdxW-1:0] RegWorkerCount = RegIdxW'(0);

  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  typedef struct packed {
    logic [TimeW-1:0] ftime;
    logic [IdxW-1:0]  idx;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic load;
  } cell_ctrl_t;

  // strict (time, index) order
  function automatic logic earlier(entry_t a, entry_t b);
    earlier = (a.ftime < b.ftime) || ((a.ftime == b.ftime) && (a.idx < b.idx));
  endfunction

endpackage

`default_nettype wire

FILE: design/earliest_free_worker_scheduler_unit.sv
// top level: job scheduler keeping worker free times in a sorted chain of cells
// the result beat is registered from the head cell in the cycle after the job beat is accepted
// a new job waits until the list update (ST_SORT) has shifted the chain and reinserted the key
// reset: all free times zero, worker i in slot i, worker_count 16
// a worker_count write clears the chain
`default_nettype none

module earliest_free_worker_scheduler_unit import efws_pkg::*; #(
  parameter int MAX_WORKERS = MaxWorkersDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // job channel
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [DurW-1:0]    job_duration_i,
  // result channel
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [IdxW-1:0]         worker_index_o,
  output logic [TimeW-1:0]        start_time_o,
  // register port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [AddrW-1:0]   paddr,
  input  wire logic [DataW-1:0]   pwdata,
  output logic [DataW-1:0]        prdata,
  output logic                    pready
);

  // worker_index is 4 bits, so at most 16 workers ever take part
  localparam int NumCells = (MAX_WORKERS < IdxLimit) ? MAX_WORKERS : IdxLimit;
  localparam logic [CntW-1:0] CapCount = CntW'(NumCells);

  typedef enum logic {
    ST_IDLE,
    ST_SORT
  } state_e;

  state_e state_q;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] active_n;
  logic out_valid_q;
  logic [IdxW-1:0] out_idx_q;
  logic [TimeW-1:0] out_time_q;
  entry_t key_q;

  logic cfg_wr;
  logic in_fire;
  cell_ctrl_t ctrl;
  logic [TimeW:0] sum;
  logic [TimeW-1:0] sum_sat;

  entry_t cell_entry [NumCells];
  logic   cell_lt    [NumCells];
  logic   cell_act   [NumCells];

  // register port: single register, writes complete in the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite
                  && (paddr[AddrW-1:2] == RegWorkerCount);

  always_comb begin
    prdata = '0;
    if (paddr[AddrW-1:2] == RegWorkerCount) begin
      prdata = DataW'(count_q);
    end
  end

  // zero means one worker, anything past the cell count saturates
  always_comb begin
    if (count_q == '0) begin
      active_n = CntW'(1);
    end else if (count_q > CapCount) begin
      active_n = CapCount;
    end else begin
      active_n = count_q;
    end
  end

  // the head cell always holds the earliest (time, index) worker
  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  // new free time of the head worker, saturating at the top of the range
  assign sum     = {1'b0, cell_entry[0].ftime} + (TimeW + 1)'(job_duration_i);
  assign sum_sat = sum[TimeW] ? TimeMax : sum[TimeW-1:0];

  assign ctrl.clear = cfg_wr;
  assign ctrl.load  = (state_q == ST_SORT);

  // chain: each cell sees its right neighbor's entry and whether it sorts before the key
  for (genvar j = 0; j < NumCells; j++) begin : g_cell
    assign cell_act[j] = (CntW'(j) < active_n);

    if (j == NumCells - 1) begin : g_last
      efws_cell #(
        .CellIdx (IdxW'(j)),
        .IsHead  (j == 0)
      ) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctrl_i       (ctrl),
        .active_i     (cell_act[j]),
        .key_i        (key_q),
        .next_entry_i (cell_entry[j]),
        .next_lt_i    (1'b0),
        .entry_o      (cell_entry[j]),
        .lt_o         (cell_lt[j])
      );
    end else begin : g_mid
      efws_cell #(
        .CellIdx (IdxW'(j)),
        .IsHead  (j == 0)
      ) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctrl_i       (ctrl),
        .active_i     (cell_act[j]),
        .key_i        (key_q),
        .next_entry_i (cell_entry[j+1]),
        .next_lt_i    (cell_lt[j+1]),
        .entry_o      (cell_entry[j]),
        .lt_o         (cell_lt[j])
      );
    end
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountReset;
    end else if (cfg_wr) begin
      count_q <= pwdata[CntW-1:0];
    end
  end

  // control: accept a job, pop the head into the result beat, then reinsert
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      out_time_q  <= '0;
      key_q       <= '0;
    end else begin
      // a new job beat refills the result register in the cycle it drains
      if (out_valid_q && out_ready_i && !in_fire) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            out_valid_q <= 1'b1;
            out_idx_q   <= cell_entry[0].idx;
            out_time_q  <= cell_entry[0].ftime;
            key_q.ftime <= sum_sat;
            key_q.idx   <= cell_entry[0].idx;
            state_q     <= ST_SORT;
          end
        end
        ST_SORT: begin
          // cells shift left past the popped head and drop the key into place
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign worker_index_o = out_idx_q;
  assign start_time_o   = out_time_q;

endmodule

`default_nettype wire

FILE: design/efws_cell.sv
// one slot of the sorted free-time list
`default_nettype none

module efws_cell import efws_pkg::*; #(
  parameter logic [IdxW-1:0] CellIdx = '0,
  parameter bit              IsHead  = 1'b0
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cell_ctrl_t ctrl_i,
  input  wire logic       active_i,
  input  wire entry_t     key_i,
  input  wire entry_t     next_entry_i,
  input  wire logic       next_lt_i,
  output entry_t          entry_o,
  output logic            lt_o
);

  entry_t entry_q, entry_d;

  assign lt_o = active_i && earlier(entry_q, key_i);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.clear) begin
      entry_d.ftime = '0;
      entry_d.idx   = CellIdx;
    end else if (ctrl_i.load && active_i) begin
      // take the neighbor while it sorts ahead of the key, else the key once
      if (next_lt_i) begin
        entry_d = next_entry_i;
      end else if (IsHead || lt_o) begin
        entry_d = key_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q.ftime <= '0;
      entry_q.idx   <= CellIdx;
    end else begin
      entry_q <= entry_d;
    end
  end

endmodule

`default_nettype wire
